>>> rtl/xwpm_pkg.sv
// Shared codes and controller/datapath interface types for the XOR window pattern matcher.
package xwpm_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam int WORD_W      = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_XOR_DEPTH      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_SELECT = 1'b1;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_TEST  = 2'd2;

   localparam logic [3:0] PAT_ZERO     = 4'd0;
   localparam logic [3:0] PAT_ONES     = 4'd1;
   localparam logic [3:0] PAT_REP_BYTE = 4'd2;
   localparam logic [3:0] PAT_ONE_HOT  = 4'd3;
   localparam logic [3:0] PAT_SE_3_3   = 4'd4;
   localparam logic [3:0] PAT_SE_7_7   = 4'd5;
   localparam logic [3:0] PAT_SE_15_15 = 4'd6;
   localparam logic [3:0] PAT_SE_0_31  = 4'd7;
   localparam logic [3:0] PAT_SE_31_0  = 4'd8;

   typedef struct packed {
      logic       clear;       // empty the window
      logic       push;        // write request word into ring
      logic       capture;     // latch test word into level-0 accumulator
      logic       rd_en;       // window read at rd_addr
      logic       acc_load;    // acc[lvl+1] = acc[lvl] ^ read data
      logic       chk_direct;  // check the test word itself
      logic [1:0] lvl;         // accumulator level in use
      logic       rsp_load;    // load output register
      logic       rsp_value;
   } cmd_type;

   typedef struct packed {
      logic       hit;         // checked word fits selected pattern
      logic [1:0] depth;       // configured XOR depth
   } status_type;

endpackage

>>> rtl/xwpm_dp.sv
// Datapath: configuration registers, window memory, XOR accumulators and pattern checker.
module xwpm_dp #(
   parameter int WINDOW_DEPTH = 16,
   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [xwpm_pkg::WORD_W-1:0]           req_data_word,
   input  logic                                  csr_write_enable,
   input  logic [xwpm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [xwpm_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  xwpm_pkg::cmd_type                     cmd,
   input  logic [AW-1:0]                         rd_addr,
   output xwpm_pkg::status_type                  status,
   output logic [CW-1:0]                         count,
   output logic                                  rsp_match_found
);
   import xwpm_pkg::*;

   logic [1:0]        xor_depth_ff, xor_depth_in;
   logic [3:0]        pattern_ff, pattern_in;
   logic [AW-1:0]     wptr_ff, wptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [WORD_W-1:0] mem [WINDOW_DEPTH];
   logic [WORD_W-1:0] rdata_ff;
   logic [WORD_W-1:0] acc0_ff, acc1_ff, acc2_ff;
   logic [WORD_W-1:0] acc_src, acc_next, chk_word;
   logic              match_ff;

   function automatic logic uni(input logic [WORD_W-1:0] v, input logic [WORD_W-1:0] m);
      logic [WORD_W-1:0] s;
      s = v & m;
      return (s == '0) || (s == m);
   endfunction

   function automatic logic pattern_ok(input logic [WORD_W-1:0] w, input logic [3:0] sel);
      logic ok;
      ok = 1'b0;
      case (sel)
         PAT_ZERO:     ok = (w == '0);
         PAT_ONES:     ok = (w == '1);
         PAT_REP_BYTE: begin
            ok = 1'b1;
            for (int k = 1; k < WORD_W / 8; k++) begin
               if (w[8*k +: 8] != w[7:0]) ok = 1'b0;
            end
         end
         PAT_ONE_HOT:  ok = (w != '0) && ((w & (w - 64'd1)) == '0);
         PAT_SE_3_3:   ok = uni(w, 64'h0000_0000_FFFF_FFF8) && uni(w, 64'hFFFF_FFF8_0000_0000);
         PAT_SE_7_7:   ok = uni(w, 64'h0000_0000_FFFF_FF80) && uni(w, 64'hFFFF_FF80_0000_0000);
         PAT_SE_15_15: ok = uni(w, 64'h0000_0000_FFFF_8000) && uni(w, 64'hFFFF_8000_0000_0000);
         PAT_SE_0_31:  ok = uni(w, 64'hFFFF_FFFF_0000_0000);
         PAT_SE_31_0:  ok = uni(w, 64'h0000_0000_FFFF_FFFF);
         default:      ok = 1'b0;
      endcase
      return ok;
   endfunction

   always_comb begin
      xor_depth_in = xor_depth_ff;
      pattern_in   = pattern_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_XOR_DEPTH:      xor_depth_in = csr_write_data[1:0];
            CSR_PATTERN_SELECT: pattern_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      wptr_in  = wptr_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         wptr_in  = '0;
         count_in = '0;
      end else if (cmd.push) begin
         wptr_in = (wptr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         if (count_ff != CW'(WINDOW_DEPTH)) count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_depth_ff <= '0;
         pattern_ff   <= '0;
         wptr_ff      <= '0;
         count_ff     <= '0;
      end else begin
         xor_depth_ff <= xor_depth_in;
         pattern_ff   <= pattern_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) mem[wptr_ff] <= req_data_word;
      if (cmd.rd_en) rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      case (cmd.lvl)
         2'd0:    acc_src = acc0_ff;
         2'd1:    acc_src = acc1_ff;
         default: acc_src = acc2_ff;
      endcase
      acc_next = acc_src ^ rdata_ff;
      chk_word = cmd.chk_direct ? acc0_ff : acc_next;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) acc0_ff <= req_data_word;
      if (cmd.acc_load && cmd.lvl == 2'd0) acc1_ff <= acc_next;
      if (cmd.acc_load && cmd.lvl != 2'd0) acc2_ff <= acc_next;
      if (cmd.rsp_load) match_ff <= cmd.rsp_value;
   end

   assign status.hit      = pattern_ok(chk_word, pattern_ff);
   assign status.depth    = xor_depth_ff;
   assign count           = count_ff;
   assign rsp_match_found = match_ff;

endmodule

>>> rtl/xwpm_ctrl.sv
// Controller: accepts transactions and walks the window index combinations for a test.
module xwpm_ctrl #(
   parameter int WINDOW_DEPTH = 16,
   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output xwpm_pkg::cmd_type    cmd,
   input  xwpm_pkg::status_type status,
   input  logic [CW-1:0]        count,
   output logic [AW-1:0]        rd_addr
);
   import xwpm_pkg::*;

   localparam int XW = (CW > 2) ? CW : 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_EV   = 3'd2;
   localparam logic [2:0] ST_NEXT = 3'd3;
   localparam logic [2:0] ST_DIR  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    lvl_ff, lvl_in;
   logic [AW-1:0] idx0_ff, idx0_in, idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic          res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, inner, slot_free;
   logic [AW-1:0] lvl_idx, start_idx;
   logic [CW-1:0] bound, idx_inc;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign inner     = (lvl_ff == status.depth - 2'd1);

   always_comb begin
      case (lvl_ff)
         2'd0: begin
            lvl_idx = idx0_ff;
            bound   = count;
         end
         2'd1: begin
            lvl_idx = idx1_ff;
            bound   = CW'(idx0_ff);
         end
         default: begin
            lvl_idx = idx2_ff;
            bound   = CW'(idx1_ff);
         end
      endcase
      idx_inc   = CW'(lvl_idx) + 1'b1;
      // lowest index of the level below that still leaves room for the deeper levels
      start_idx = AW'(status.depth - 2'd2 - lvl_ff);
   end

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      idx0_in  = idx0_ff;
      idx1_in  = idx1_ff;
      idx2_in  = idx2_ff;
      res_in   = res_ff;
      cmd      = '0;
      cmd.lvl  = lvl_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.lvl = 2'd0;
            if (accept) begin
               case (req_opcode)
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_PUSH:  cmd.push  = 1'b1;
                  OP_TEST: begin
                     cmd.capture = 1'b1;
                     lvl_in      = 2'd0;
                     idx0_in     = AW'(status.depth - 2'd1);
                     if (status.depth == 2'd0) begin
                        state_in = ST_DIR;
                     end else if (XW'(count) < XW'(status.depth)) begin
                        res_in   = 1'b0;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EV;
         end
         ST_EV: begin
            if (inner) begin
               if (status.hit) begin
                  res_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_NEXT;
               end
            end else begin
               cmd.acc_load = 1'b1;
               lvl_in       = lvl_ff + 2'd1;
               if (lvl_ff == 2'd0) idx1_in = start_idx;
               else idx2_in = start_idx;
               state_in = ST_RD;
            end
         end
         ST_NEXT: begin
            if (idx_inc < bound) begin
               case (lvl_ff)
                  2'd0:    idx0_in = AW'(idx_inc);
                  2'd1:    idx1_in = AW'(idx_inc);
                  default: idx2_in = AW'(idx_inc);
               endcase
               state_in = ST_RD;
            end else if (lvl_ff == 2'd0) begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               lvl_in = lvl_ff - 2'd1;
            end
         end
         ST_DIR: begin
            cmd.lvl        = 2'd0;
            cmd.chk_direct = 1'b1;
            res_in         = status.hit;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_value = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx0_ff <= idx0_in;
      idx1_ff <= idx1_in;
      idx2_ff <= idx2_in;
      res_ff  <= res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = lvl_idx;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while a transaction is pending");

   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV || state_ff == ST_RD) |-> (lvl_ff < status.depth))
      else $error("search level beyond configured depth");

   a_rd_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (CW'(rd_addr) < count))
      else $error("window read outside valid entries");

   a_direct: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_TEST && status.depth == 2'd0) |=> (state_ff == ST_DIR))
      else $error("depth-zero test did not take the direct check");

endmodule

>>> rtl/xor_window_pattern_matcher_unit.sv
// Top level of the XOR window pattern matcher: controller plus datapath.
// A test is checked against the selected pattern after XOR with every set of xor_depth
// distinct window words. The single window memory read port and one pattern checker take
// each combination through read, check and step states, and each partial selection of the
// outer indexes through read, accumulate and step states, ending early at the first match.
// At depth 0 the test word itself is checked, and when the window holds fewer than xor_depth
// words the result is no match without a search. A finished result waits in the output
// register while the next transaction is taken; a second result holds the controller, and
// so the input, until that register frees.
module xor_window_pattern_matcher_unit #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic [xwpm_pkg::WORD_W-1:0]      req_data_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_match_found,
   input  logic                             csr_write_enable,
   input  logic [xwpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xwpm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import xwpm_pkg::*;

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(WINDOW_DEPTH + 1);

   cmd_type       cmd;
   status_type    status;
   logic [CW-1:0] count;
   logic [AW-1:0] rd_addr;

   xwpm_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status),
      .count      (count),
      .rd_addr    (rd_addr)
   );

   xwpm_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data_word    (req_data_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .status           (status),
      .count            (count),
      .rsp_match_found  (rsp_match_found)
   );

endmodule

>>> tb/sv/xor_window_pattern_matcher_unit_test.sv
// Self-checking testbench for the XOR window pattern matcher unit.
`timescale 1ns / 100ps

module xor_window_pattern_matcher_unit_test;
   import xwpm_pkg::*;

   localparam int WIN_DEPTH = 16;
   localparam int CLK_HALF = 4;
   localparam int RANDOM_ITEMS = 1000;
   localparam int NUM_PHASES = 12;
   localparam int LONG_HOLD = 600;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS = 20;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam logic [3:0] PAT_UNUSED_LO = 4'd9;
   localparam logic [3:0] PAT_UNUSED_HI = 4'd15;

   typedef struct {
      logic [1:0]        op;
      logic [WORD_W-1:0] data;
      bit                pause;   // sender waits here until all results are back
   } word_txn_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_opcode = OP_CLEAR;
   logic [WORD_W-1:0]      req_data_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_match_found;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_XOR_DEPTH;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // predictor state, updated as transactions are accepted
   logic [WORD_W-1:0] win_mem [WIN_DEPTH];
   int                win_count = 0;
   int                win_wp = 0;
   logic [1:0]        cfg_depth = 2'd0;
   logic [3:0]        cfg_pattern = PAT_ZERO;
   bit                expected_matches [$];

   // mirror of the window at generation time, used to build matching test words
   logic [WORD_W-1:0] gen_mem [WIN_DEPTH];
   int                gen_count = 0;
   int                gen_wp = 0;

   word_txn_type pending_txns [$];
   word_txn_type next_txn;
   longint    cycle_budget = 0;
   longint    cycle_count = 0;
   int        items_queued = 0;
   int        results_checked = 0;
   int        hits_seen = 0;
   int        errors = 0;
   int        settings_applied = 0;
   int        hold_requests = 0;
   int        hold_seen = 0;
   int        burst_left = 0;
   int        gap_left = 0;
   int        hold_left = 0;
   int        stall_mode = 0;
   int        mode_left = 0;
   int        stall_phase = 0;
   bit        exp_match;

   xor_window_pattern_matcher_unit #(
      .WINDOW_DEPTH(WIN_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_data_word(req_data_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_match_found(rsp_match_found),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #(CLK_HALF) clock = ~clock;

   function automatic bit uniform_bits(logic [WORD_W-1:0] w, int lo, int hi);
      for (int i = lo; i <= hi; i++) begin
         if (w[i] !== w[lo]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void se_bounds(input logic [3:0] pat, output int upper, output int lower);
      case (pat)
         PAT_SE_3_3: begin
            upper = 3;
            lower = 3;
         end
         PAT_SE_7_7: begin
            upper = 7;
            lower = 7;
         end
         PAT_SE_15_15: begin
            upper = 15;
            lower = 15;
         end
         PAT_SE_0_31: begin
            upper = 0;
            lower = 31;
         end
         default: begin
            upper = 31;
            lower = 0;
         end
      endcase
   endfunction

   function automatic bit fits_pattern(logic [WORD_W-1:0] w, logic [3:0] pat);
      int upper, lower;
      case (pat)
         PAT_ZERO: return w == '0;
         PAT_ONES: return &w;
         PAT_REP_BYTE: return w == {8{w[7:0]}};
         PAT_ONE_HOT: return (w != '0) && ((w & (w - 64'd1)) == '0);
         PAT_SE_3_3, PAT_SE_7_7, PAT_SE_15_15, PAT_SE_0_31, PAT_SE_31_0: begin
            se_bounds(pat, upper, lower);
            return uniform_bits(w, lower, 31) && uniform_bits(w, upper + 32, 63);
         end
         default: return 1'b0;
      endcase
   endfunction

   // any set of cfg_depth distinct valid window words that brings t onto the pattern
   function automatic bit window_has_match(logic [WORD_W-1:0] t);
      case (cfg_depth)
         2'd0: return fits_pattern(t, cfg_pattern);
         2'd1: begin
            for (int a = 0; a < win_count; a++)
               if (fits_pattern(t ^ win_mem[a], cfg_pattern)) return 1'b1;
         end
         2'd2: begin
            for (int a = 0; a < win_count; a++)
               for (int b = 0; b < a; b++)
                  if (fits_pattern(t ^ win_mem[a] ^ win_mem[b], cfg_pattern)) return 1'b1;
         end
         default: begin
            for (int a = 0; a < win_count; a++)
               for (int b = 0; b < a; b++)
                  for (int c = 0; c < b; c++)
                     if (fits_pattern(t ^ win_mem[a] ^ win_mem[b] ^ win_mem[c], cfg_pattern))
                        return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void apply_to_window(logic [1:0] op, logic [WORD_W-1:0] data);
      case (op)
         OP_CLEAR: begin
            win_count = 0;
            win_wp = 0;
         end
         OP_PUSH: begin
            win_mem[win_wp] = data;
            win_wp = (win_wp + 1) % WIN_DEPTH;
            if (win_count < WIN_DEPTH) win_count++;
         end
         OP_TEST: expected_matches.push_back(window_has_match(data));
         default: ;
      endcase
   endfunction

   function automatic longint binom(int n, int k);
      longint r;
      r = 1;
      if (k < 0 || k > n) return 0;
      for (int i = 0; i < k; i++) r = r * (n - i) / (i + 1);
      return r;
   endfunction

   // cycle estimate for a test, from the number of visited search nodes
   function automatic longint test_cost(int n, int d);
      longint nodes;
      nodes = 0;
      if (d == 0) return 3;
      if (n < d) return 2;
      for (int j = 0; j < d; j++) nodes += binom(n - j, d - j);
      return 3 * nodes + 2;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [WORD_W-1:0] pattern_word(logic [3:0] pat);
      logic [WORD_W-1:0] w;
      int                upper, lower;
      bit                lo_bit, hi_bit;
      w = rand_word();
      case (pat)
         PAT_ZERO: w = '0;
         PAT_ONES: w = '1;
         PAT_REP_BYTE: w = {8{w[7:0]}};
         PAT_ONE_HOT: w = 64'd1 << $urandom_range(63);
         PAT_SE_3_3, PAT_SE_7_7, PAT_SE_15_15, PAT_SE_0_31, PAT_SE_31_0: begin
            se_bounds(pat, upper, lower);
            lo_bit = 1'($urandom_range(1));
            hi_bit = 1'($urandom_range(1));
            for (int i = lower; i <= 31; i++) w[i] = lo_bit;
            for (int i = upper + 32; i <= 63; i++) w[i] = hi_bit;
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] extreme_word();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return {32'h0000_0000, 32'hFFFF_FFFF};
         default: return {32'hFFFF_FFFF, 32'h0000_0000};
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] push_word();
      int r;
      r = $urandom_range(99);
      if (r < 80) return rand_word();
      if (r < 90) return pattern_word(cfg_pattern);
      return extreme_word();
   endfunction

   // mostly words that hit the pattern through some window combination, some one bit off
   function automatic logic [WORD_W-1:0] craft_test_word();
      logic [WORD_W-1:0] w;
      int                picks [3];
      int                r;
      r = $urandom_range(99);
      if (r >= 80) return rand_word();
      if (r >= 70) return extreme_word();
      w = pattern_word(cfg_pattern);
      if (gen_count >= cfg_depth) begin
         for (int k = 0; k < cfg_depth; k++) begin
            do picks[k] = $urandom_range(gen_count - 1);
            while (k > 0 && (picks[k] == picks[0] || (k > 1 && picks[k] == picks[1])));
            w ^= gen_mem[picks[k]];
         end
      end
      if (r >= 50) w ^= 64'd1 << $urandom_range(63);
      return w;
   endfunction

   function automatic void queue_txn(logic [1:0] op, logic [WORD_W-1:0] data);
      word_txn_type t;
      t.op = op;
      t.data = data;
      t.pause = 1'b0;
      pending_txns.push_back(t);
      case (op)
         OP_CLEAR: begin
            gen_count = 0;
            gen_wp = 0;
         end
         OP_PUSH: begin
            gen_mem[gen_wp] = data;
            gen_wp = (gen_wp + 1) % WIN_DEPTH;
            if (gen_count < WIN_DEPTH) gen_count++;
         end
         OP_TEST: cycle_budget += test_cost(gen_count, cfg_depth);
         default: ;
      endcase
      cycle_budget += 60;
      if (op != OP_RESERVED) items_queued++;
   endfunction

   function automatic void queue_pause();
      word_txn_type t;
      t.op = OP_RESERVED;
      t.data = '0;
      t.pause = 1'b1;
      pending_txns.push_back(t);
   endfunction

   function automatic void build_phase(int target);
      int         made, pushes, tests, r;
      bit         paused;
      logic [1:0] op;
      made = 0;
      paused = 1'b0;
      while (made < target) begin
         if (!paused && made >= target / 2) begin
            queue_pause();
            paused = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 80) begin
            if ($urandom_range(99) < 85) begin
               queue_txn(OP_CLEAR, rand_word());
               made++;
            end
            r = $urandom_range(99);
            pushes = (r < 70) ? $urandom_range(6) :
                     (r < 95) ? $urandom_range(12, 7) : $urandom_range(24, 13);
            for (int i = 0; i < pushes; i++) begin
               queue_txn(OP_PUSH, push_word());
               made++;
            end
            tests = $urandom_range(5, 1);
            for (int i = 0; i < tests; i++) begin
               queue_txn(OP_TEST, craft_test_word());
               made++;
            end
         end else if (r < 93) begin
            op = 2'($urandom_range(3));
            queue_txn(op, rand_word());
            if (op != OP_RESERVED) made++;
         end else begin
            queue_pause();
            queue_txn(OP_TEST, craft_test_word());
            made++;
         end
      end
   endfunction

   function automatic void phase_setting(input int p, output logic [1:0] depth,
                                         output logic [3:0] pat);
      case (p)
         0: begin depth = 2'd0; pat = PAT_ZERO; end
         1: begin depth = 2'd1; pat = PAT_ONES; end
         2: begin depth = 2'd2; pat = PAT_REP_BYTE; end
         3: begin depth = 2'd3; pat = PAT_ONE_HOT; end
         4: begin depth = 2'd1; pat = PAT_SE_3_3; end
         5: begin depth = 2'd2; pat = PAT_SE_7_7; end
         6: begin depth = 2'd3; pat = PAT_SE_15_15; end
         7: begin depth = 2'd1; pat = PAT_SE_0_31; end
         8: begin depth = 2'd3; pat = PAT_SE_31_0; end
         9: begin depth = 2'd2; pat = PAT_UNUSED_LO; end
         10: begin depth = 2'd0; pat = PAT_SE_15_15; end
         default: begin depth = 2'd3; pat = PAT_ZERO; end
      endcase
   endfunction

   task automatic set_config(logic [1:0] depth, logic [3:0] pat);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_XOR_DEPTH;
      csr_write_data <= {2'b00, depth};
      @(posedge clock);
      csr_index <= CSR_PATTERN_SELECT;
      csr_write_data <= pat;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_depth = depth;
      cfg_pattern = pat;
      settings_applied++;
      cycle_budget += 100;
   endtask

   // all transactions sent and all results back, then a settling wait of SETTLE_CYCLES
   task automatic wait_idle();
      while (pending_txns.size() != 0 || req_valid || expected_matches.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sender: bursts with random gaps, predicts each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_to_window(req_opcode, req_data_word);
         if (!req_valid || !req_stall) begin
            if (pending_txns.size() != 0 && pending_txns[0].pause) begin
               if (expected_matches.size() == 0) void'(pending_txns.pop_front());
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_txns.size() != 0) begin
               next_txn = pending_txns.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_txn.op;
               req_data_word <= next_txn.data;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(24, 1);
                  case ($urandom_range(9))
                     0, 1, 2, 3: gap_left = 0;
                     9: gap_left = $urandom_range(30, 10);
                     default: gap_left = $urandom_range(6, 1);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern; a requested long hold lets the block back up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(2);
            mode_left = $urandom_range(400, 32);
         end else begin
            mode_left--;
         end
         stall_phase = (stall_phase + 1) % 5;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(99) < 35);
            default: rsp_stall <= (stall_phase < 2);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matches.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected transaction, match_found=%0b", $time, rsp_match_found);
         end else begin
            exp_match = expected_matches.pop_front();
            results_checked++;
            if (rsp_match_found) hits_seen++;
            if (rsp_match_found !== exp_match) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: match_found mismatch, expected %0b actual %0b",
                           $time, exp_match, rsp_match_found);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * cycle_budget + 20000) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_matches.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [1:0] depth;
      logic [3:0] pat;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, depth 0 against all-zero
      queue_txn(OP_TEST, '0);
      queue_txn(OP_TEST, '1);
      queue_txn(OP_RESERVED, '1);
      queue_txn(OP_TEST, 64'd1);
      queue_txn(OP_PUSH, '1);
      queue_txn(OP_PUSH, '0);
      queue_txn(OP_PUSH, 64'h0123_4567_89AB_CDEF);
      queue_txn(OP_CLEAR, '1);
      queue_txn(OP_TEST, '0);
      wait_idle();

      // triples with too few words, then a real triple hit
      set_config(2'd3, PAT_ONES);
      @(negedge clock);
      queue_txn(OP_PUSH, 64'h00FF_00FF_00FF_00FF);
      queue_txn(OP_PUSH, 64'hF0F0_F0F0_F0F0_F0F0);
      queue_txn(OP_TEST, '1);
      queue_txn(OP_PUSH, 64'h0123_4567_89AB_CDEF);
      queue_txn(OP_TEST, ~(64'h00FF_00FF_00FF_00FF ^ 64'hF0F0_F0F0_F0F0_F0F0 ^
                           64'h0123_4567_89AB_CDEF));
      queue_txn(OP_TEST, '1);
      wait_idle();

      // unused pattern code never matches
      set_config(2'd1, PAT_UNUSED_HI);
      @(negedge clock);
      queue_txn(OP_TEST, '0);
      queue_txn(OP_TEST, 64'h00FF_00FF_00FF_00FF);
      wait_idle();

      set_config(2'd2, PAT_SE_31_0);
      @(negedge clock);
      queue_txn(OP_TEST, 64'h00FF_00FF_00FF_00FF ^ 64'hF0F0_F0F0_F0F0_F0F0);
      queue_txn(OP_TEST, rand_word());
      wait_idle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         phase_setting(p, depth, pat);
         set_config(depth, pat);
         @(negedge clock);
         if (p % 4 == 1) begin
            hold_requests++;
            cycle_budget += LONG_HOLD;
         end
         build_phase(RANDOM_ITEMS / NUM_PHASES);
         wait_idle();
      end

      $display("Covered %0d transactions, %0d tests checked (%0d hits), %0d register settings",
               items_queued, results_checked, hits_seen, settings_applied);
      $display("XOR depths 0..3, every pattern and unused codes, ring wrap, output backpressure");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/xwpm_pkg.sv
rtl/xwpm_dp.sv
rtl/xwpm_ctrl.sv
rtl/xor_window_pattern_matcher_unit.sv
tb/sv/xor_window_pattern_matcher_unit_test.sv
